FILE: rtl/core/http_request_header_parser_assert.svh
// assertion macros for the http request header parser
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define HRHP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hrhp same-cycle check failed");
// next-cycle implication, disabled while in reset
`define HRHP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hrhp next-cycle check failed");
`else
`define HRHP_ASSERT_IMP(lbl, ante, cons)
`define HRHP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/hrhp_pkg.sv
// shared types and codes for the http request header parser
package hrhp_pkg;

    // parse phase codes
    localparam logic [4:0] PH_REQ_START  = 5'd0;
    localparam logic [4:0] PH_METHOD     = 5'd1;
    localparam logic [4:0] PH_URI        = 5'd2;
    localparam logic [4:0] PH_PROTO_H    = 5'd3;
    localparam logic [4:0] PH_PROTO_T1   = 5'd4;
    localparam logic [4:0] PH_PROTO_T2   = 5'd5;
    localparam logic [4:0] PH_PROTO_P    = 5'd6;
    localparam logic [4:0] PH_SLASH      = 5'd7;
    localparam logic [4:0] PH_MAJ_FIRST  = 5'd8;
    localparam logic [4:0] PH_MAJ        = 5'd9;
    localparam logic [4:0] PH_MIN_FIRST  = 5'd10;
    localparam logic [4:0] PH_MIN        = 5'd11;
    localparam logic [4:0] PH_LF_REQLINE = 5'd12;
    localparam logic [4:0] PH_LINE_START = 5'd13;
    localparam logic [4:0] PH_FOLD       = 5'd14;
    localparam logic [4:0] PH_NAME       = 5'd15;
    localparam logic [4:0] PH_COLON_SP   = 5'd16;
    localparam logic [4:0] PH_VALUE      = 5'd17;
    localparam logic [4:0] PH_LF_HEADER  = 5'd18;
    localparam logic [4:0] PH_LF_END     = 5'd19;
    localparam logic [4:0] PH_FAILED     = 5'd20;
    localparam logic [4:0] PH_BODY       = 5'd21;

    // host name match position meaning the name differs
    localparam logic [2:0] MATCH_NONE = 3'd7;
    localparam logic [2:0] MATCH_FULL = 3'd4;

    // status codes
    localparam logic [1:0] ST_CONT = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // byte role codes
    localparam logic [2:0] ROLE_DELIM = 3'd0;
    localparam logic [2:0] ROLE_METH  = 3'd1;
    localparam logic [2:0] ROLE_URI   = 3'd2;
    localparam logic [2:0] ROLE_NAME  = 3'd3;
    localparam logic [2:0] ROLE_VAL   = 3'd4;
    localparam logic [2:0] ROLE_SKIP  = 3'd5;
    localparam logic [2:0] ROLE_BODY  = 3'd6;

    // parser state carried from byte to byte
    typedef struct packed {
        logic [4:0] phase;
        logic [7:0] major_acc;
        logic [7:0] minor_acc;
        logic [7:0] headers_seen;
        logic [2:0] host_pos;
        logic       is_host;
    } t_state;

    // per-byte tags
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] role;
        logic       header_begin;
        logic       host_value;
    } t_tag;

    localparam t_state STATE_RESET = '{
        phase:        PH_REQ_START,
        major_acc:    8'd0,
        minor_acc:    8'd0,
        headers_seen: 8'd0,
        host_pos:     3'd0,
        is_host:      1'b0
    };

endpackage

FILE: rtl/core/hrhp_step.sv
// combinational per-byte parse step: next state and byte tags
module hrhp_step
    import hrhp_pkg::*;
(
    input  t_state     i_state,
    input  logic       i_new_request,
    input  logic [7:0] i_data_byte,
    output t_state     o_state,
    output t_tag       o_tag
);

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_cntrl(input logic [7:0] c);
        return c < 8'h20 || c == 8'h7f;
    endfunction

    // letters of the word Host
    function automatic logic [7:0] host_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = 8'h48;
            2'd1:    ch = 8'h6f;
            2'd2:    ch = 8'h73;
            default: ch = 8'h74;
        endcase
        return ch;
    endfunction

    // acc * 10 + digit, saturating at 255
    function automatic logic [7:0] dec_push(input logic [7:0] acc, input logic [7:0] c);
        logic [11:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, c[3:0]};
        return (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;

    t_state     cur;
    t_state     nxt;
    t_tag       tag;
    logic       bad;
    logic [7:0] c;
    logic       alnum;
    logic       blank;

    assign c     = i_data_byte;
    assign alnum = is_alpha(c) || is_digit(c);
    assign blank = (c == CH_SP) || (c == CH_TAB);
    // a new request restarts from the reset state before this byte
    assign cur   = i_new_request ? STATE_RESET : i_state;

    always_comb begin
        nxt = cur;
        tag = '{status: ST_CONT, role: ROLE_DELIM, header_begin: 1'b0, host_value: 1'b0};
        bad = 1'b0;
        unique case (cur.phase)
            PH_REQ_START: begin
                if (is_alpha(c)) begin
                    nxt.phase = PH_METHOD;
                    tag.role  = ROLE_METH;
                end else bad = 1'b1;
            end
            PH_METHOD: begin
                if (c == CH_SP) nxt.phase = PH_URI;
                else if (is_alpha(c)) tag.role = ROLE_METH;
                else bad = 1'b1;
            end
            PH_URI: begin
                if (c == CH_SP) nxt.phase = PH_PROTO_H;
                else if (is_cntrl(c)) bad = 1'b1;
                else tag.role = ROLE_URI;
            end
            PH_PROTO_H: begin
                if (c == CH_H) nxt.phase = PH_PROTO_T1; else bad = 1'b1;
            end
            PH_PROTO_T1: begin
                if (c == CH_T) nxt.phase = PH_PROTO_T2; else bad = 1'b1;
            end
            PH_PROTO_T2: begin
                if (c == CH_T) nxt.phase = PH_PROTO_P; else bad = 1'b1;
            end
            PH_PROTO_P: begin
                if (c == CH_P) nxt.phase = PH_SLASH; else bad = 1'b1;
            end
            PH_SLASH: begin
                if (c == CH_SLASH) begin
                    nxt.major_acc = 8'd0;
                    nxt.minor_acc = 8'd0;
                    nxt.phase     = PH_MAJ_FIRST;
                end else bad = 1'b1;
            end
            PH_MAJ_FIRST: begin
                if (is_digit(c)) begin
                    nxt.major_acc = dec_push(cur.major_acc, c);
                    nxt.phase     = PH_MAJ;
                end else bad = 1'b1;
            end
            PH_MAJ: begin
                if (c == CH_DOT) nxt.phase = PH_MIN_FIRST;
                else if (is_digit(c)) nxt.major_acc = dec_push(cur.major_acc, c);
                else bad = 1'b1;
            end
            PH_MIN_FIRST: begin
                if (is_digit(c)) begin
                    nxt.minor_acc = dec_push(cur.minor_acc, c);
                    nxt.phase     = PH_MIN;
                end else bad = 1'b1;
            end
            PH_MIN: begin
                if (c == CH_CR) nxt.phase = PH_LF_REQLINE;
                else if (is_digit(c)) nxt.minor_acc = dec_push(cur.minor_acc, c);
                else bad = 1'b1;
            end
            PH_LF_REQLINE: begin
                if (c == CH_LF) nxt.phase = PH_LINE_START; else bad = 1'b1;
            end
            PH_LINE_START: begin
                if (c == CH_CR) begin
                    nxt.phase = PH_LF_END;
                end else if (cur.headers_seen != 8'd0 && blank) begin
                    nxt.phase = PH_FOLD;
                end else if (!alnum) begin
                    tag.role = ROLE_SKIP;
                end else begin
                    // first byte of a new header name
                    if (cur.headers_seen != 8'd255) nxt.headers_seen = cur.headers_seen + 8'd1;
                    nxt.host_pos     = (c == host_char(2'd0)) ? 3'd1 : MATCH_NONE;
                    nxt.is_host      = 1'b0;
                    tag.role         = ROLE_NAME;
                    tag.header_begin = 1'b1;
                    nxt.phase        = PH_NAME;
                end
            end
            PH_FOLD: begin
                if (c == CH_CR) nxt.phase = PH_LF_HEADER;
                else if (blank) begin
                    // folding whitespace stays a delimiter
                end else if (is_cntrl(c)) bad = 1'b1;
                else begin
                    tag.role       = ROLE_VAL;
                    tag.host_value = cur.is_host;
                    nxt.phase      = PH_VALUE;
                end
            end
            PH_NAME: begin
                if (c == CH_COLON) begin
                    nxt.is_host = (cur.host_pos == MATCH_FULL);
                    nxt.phase   = PH_COLON_SP;
                end else if (alnum) begin
                    tag.role = ROLE_NAME;
                    if (cur.host_pos < MATCH_FULL && c == host_char(cur.host_pos[1:0]))
                        nxt.host_pos = cur.host_pos + 3'd1;
                    else
                        nxt.host_pos = MATCH_NONE;
                end else bad = 1'b1;
            end
            PH_COLON_SP: begin
                if (c == CH_SP) nxt.phase = PH_VALUE; else bad = 1'b1;
            end
            PH_VALUE: begin
                if (c == CH_CR) nxt.phase = PH_LF_HEADER;
                else if (is_cntrl(c)) bad = 1'b1;
                else begin
                    tag.role       = ROLE_VAL;
                    tag.host_value = cur.is_host;
                end
            end
            PH_LF_HEADER: begin
                if (c == CH_LF) nxt.phase = PH_LINE_START; else bad = 1'b1;
            end
            PH_LF_END: begin
                if (c == CH_LF) begin
                    tag.status = ST_DONE;
                    nxt.phase  = PH_BODY;
                end else bad = 1'b1;
            end
            PH_BODY: begin
                tag.status = ST_DONE;
                tag.role   = ROLE_BODY;
            end
            // failed phase and unused codes stay in error
            default: bad = 1'b1;
        endcase

        // any bad byte forces the error phase and plain error tags
        if (bad) begin
            nxt.phase = PH_FAILED;
            tag       = '{status: ST_ERR, role: ROLE_DELIM, header_begin: 1'b0,
                          host_value: 1'b0};
        end
    end

    assign o_state = nxt;
    assign o_tag   = tag;

endmodule

FILE: rtl/core/http_request_header_parser.sv
// top level of the http request header parser
// Usage: one request byte per input beat on i_valid / o_ready, carrying
// i_data_byte and i_new_request (restart at request start before this byte).
// Every input beat yields exactly one result beat on o_valid / i_ready with
// status, byte role, header begin and host flags, and the running version
// numbers and header count as they stand after that byte.
// An accepted byte passes through the input register and then the result
// register before its result shows; a receiver stall can hold it between.
// Throughput: one byte per cycle while results are taken; the parse state
// update between the input and result registers is the loop that sets it.
// Reset (synchronous, active low) empties both registers and returns the
// parse state to request start with all counters at zero.
// When the receiver stalls, the result holds and one more byte waits in the
// input register; o_ready drops only once both are full, and rises again in
// the cycle the held result is taken.
`include "http_request_header_parser_assert.svh"

module http_request_header_parser
    import hrhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_new_request,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [2:0] o_byte_role,
    output logic       o_header_begin,
    output logic       o_host_value,
    output logic [7:0] o_major_version,
    output logic [7:0] o_minor_version,
    output logic [7:0] o_header_count
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_new;
    t_state     r_state;
    t_state     n_state;
    t_tag       n_tag;
    logic       r_out_valid;
    t_tag       r_out_tag;
    logic [7:0] r_out_major;
    logic [7:0] r_out_minor;
    logic [7:0] r_out_count;
    logic       advance;

    // the input beat moves on when the result slot is free or being taken
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_new  <= i_new_request;
        end
    end

    hrhp_step u_step (
        .i_state       (r_state),
        .i_new_request (r_in_new),
        .i_data_byte   (r_in_byte),
        .o_state       (n_state),
        .o_tag         (n_tag)
    );

    // parse state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_tag   <= n_tag;
            r_out_major <= n_state.major_acc;
            r_out_minor <= n_state.minor_acc;
            r_out_count <= n_state.headers_seen;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_tag.status;
    assign o_byte_role     = r_out_tag.role;
    assign o_header_begin  = r_out_tag.header_begin;
    assign o_host_value    = r_out_tag.host_value;
    assign o_major_version = r_out_major;
    assign o_minor_version = r_out_minor;
    assign o_header_count  = r_out_count;

    // checks
    `HRHP_ASSERT_IMP(a_err_matches_phase, o_valid && o_status == ST_ERR, r_state.phase == PH_FAILED)
    `HRHP_ASSERT_IMP(a_done_matches_phase, o_valid && o_status == ST_DONE, r_state.phase == PH_BODY)
    `HRHP_ASSERT_IMP(a_begin_is_name, o_valid && o_header_begin,
                     o_byte_role == ROLE_NAME && o_header_count != 8'd0)
    `HRHP_ASSERT_NXT(a_error_sticky, advance && !r_in_new && r_state.phase == PH_FAILED,
                     o_valid && o_status == ST_ERR)

endmodule
